[rtl/indexed_shift_queue_macros.svh]
// ----------------------------------------------------------------------------
// indexed_shift_queue assertion macros
// Concurrent assertion wrappers; compiled out when SYNTH is defined.
// ----------------------------------------------------------------------------
`ifndef INDEXED_SHIFT_QUEUE_MACROS_SVH
`define INDEXED_SHIFT_QUEUE_MACROS_SVH

`ifndef SYNTH
// clocked check, masked while reset is high
`define ISQ_ASSERT(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
// clocked check that also runs through reset
`define ISQ_ASSERT_NR(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define ISQ_ASSERT(lbl, clk, rst, prop, msg)
`define ISQ_ASSERT_NR(lbl, clk, prop, msg)
`endif

`endif

[rtl/isq_pkg.sv]
// ----------------------------------------------------------------------------
// isq_pkg
// Request/status codes and channel payload types for the shift queue.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package isq_pkg;

  typedef logic [2:0] op_t;
  typedef logic [2:0] status_t;

  localparam op_t OP_APPEND = 3'd0;
  localparam op_t OP_INSERT = 3'd1;
  localparam op_t OP_ERASE  = 3'd2;
  localparam op_t OP_POP    = 3'd3;
  localparam op_t OP_CLEAR  = 3'd4;
  localparam op_t OP_RESIZE = 3'd5;
  localparam op_t OP_FILL   = 3'd6;

  localparam status_t ST_OK      = 3'd0;
  localparam status_t ST_FULL    = 3'd1;
  localparam status_t ST_RANGE   = 3'd2;
  localparam status_t ST_EMPTY   = 3'd3;
  localparam status_t ST_CLAMPED = 3'd4;
  localparam status_t ST_SAME    = 3'd5;

  typedef struct packed {
    op_t         req_type;
    logic [4:0]  position;
    logic [4:0]  amount;
    logic [15:0] entry_value;
  } req_t;

  typedef struct packed {
    status_t     status;
    logic [15:0] popped_value;
    logic [4:0]  length_after;
  } res_t;

endpackage

[rtl/isq_ifs.sv]
// ----------------------------------------------------------------------------
// isq channel interfaces
// Valid/ready request and response channels of the shift queue.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface isq_req_if;
  logic        valid;
  logic        ready;
  logic [2:0]  req_type;
  logic [4:0]  position;
  logic [4:0]  amount;
  logic [15:0] entry_value;

  modport source (output valid, req_type, position, amount, entry_value, input ready);
  modport sink   (input valid, req_type, position, amount, entry_value, output ready);
endinterface

interface isq_rsp_if;
  logic        valid;
  logic        ready;
  logic [2:0]  status;
  logic [15:0] popped_value;
  logic [4:0]  length_after;

  modport source (output valid, status, popped_value, length_after, input ready);
  modport sink   (input valid, status, popped_value, length_after, output ready);
endinterface

[rtl/indexed_shift_queue.sv]
// ----------------------------------------------------------------------------
// indexed_shift_queue
// Bounded ordered list of entry handles with insert/erase/pop/resize/fill.
//   req (sink) carries one request per transfer; rsp (source) returns one
//   result per request: status, popped entry and the new length.
//   Requests are taken one at a time; req.ready is high only while the
//   sequencer is idle. Insert, erase, pop and fill walk a slot cursor
//   through a single one-write/one-read RAM; a shifted slot is read, then
//   written. Insert shifts the slots from position up; erase shifts the
//   slots above the run down and zeroes the vacated tail; pop captures
//   slot 0, then shifts down like an erase of one; fill writes all DEPTH
//   slots. Append writes one slot; clear, resize and rejected requests
//   write none.
//   After reset the block zeroes all DEPTH slots with req.ready low. A
//   result is held in an output register; while rsp is stalled a new
//   request is still taken, and its result waits until the register is
//   free.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module indexed_shift_queue #(
  parameter int DEPTH      = 16,
  parameter int ENTRY_BITS = 16
) (
  input logic      clk,
  input logic      rst,
  isq_req_if.sink   req,
  isq_rsp_if.source rsp
);

  import isq_pkg::*;

  localparam int AW = $clog2(DEPTH);

  req_t                  req_data;
  res_t                  res;
  res_t                  out_data;
  logic                  in_ready, in_fire;
  logic                  res_valid, res_free;
  logic                  out_valid;
  logic                  ram_we;
  logic [AW-1:0]         ram_waddr, ram_raddr;
  logic [ENTRY_BITS-1:0] ram_wdata, ram_rdata;

  assign req_data.req_type    = req.req_type;
  assign req_data.position    = req.position;
  assign req_data.amount      = req.amount;
  assign req_data.entry_value = req.entry_value;

  assign req.ready = in_ready;
  assign in_fire   = req.valid && in_ready;
  assign res_free  = !out_valid || rsp.ready;

  isq_ctrl #(
    .DEPTH      (DEPTH),
    .ENTRY_BITS (ENTRY_BITS)
  ) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_fire   (in_fire),
    .req       (req_data),
    .in_ready  (in_ready),
    .res_free  (res_free),
    .res_valid (res_valid),
    .res       (res),
    .ram_we    (ram_we),
    .ram_waddr (ram_waddr),
    .ram_wdata (ram_wdata),
    .ram_raddr (ram_raddr),
    .ram_rdata (ram_rdata)
  );

  isq_slot_ram #(
    .DEPTH      (DEPTH),
    .ENTRY_BITS (ENTRY_BITS)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res_valid) begin
      out_valid <= 1'b1;
    end else if (rsp.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid) begin
      out_data <= res;
    end
  end

  assign rsp.valid        = out_valid;
  assign rsp.status       = out_data.status;
  assign rsp.popped_value = out_data.popped_value;
  assign rsp.length_after = out_data.length_after;

endmodule

[rtl/isq_slot_ram.sv]
// ----------------------------------------------------------------------------
// isq_slot_ram
// Slot storage: one write port, one read port with registered read data.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module isq_slot_ram #(
  parameter int DEPTH      = 16,
  parameter int ENTRY_BITS = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [ENTRY_BITS-1:0]    wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [ENTRY_BITS-1:0]    rdata
);

  logic [ENTRY_BITS-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

[rtl/isq_ctrl.sv]
// ----------------------------------------------------------------------------
// isq_ctrl
// Request sequencer: walks a slot cursor through the RAM to shift, zero
// and fill, and keeps the list length.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "indexed_shift_queue_macros.svh"

module isq_ctrl #(
  parameter int DEPTH      = 16,
  parameter int ENTRY_BITS = 16
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     in_fire,
  input  isq_pkg::req_t            req,
  output logic                     in_ready,
  input  logic                     res_free,
  output logic                     res_valid,
  output isq_pkg::res_t            res,
  output logic                     ram_we,
  output logic [$clog2(DEPTH)-1:0] ram_waddr,
  output logic [ENTRY_BITS-1:0]    ram_wdata,
  output logic [$clog2(DEPTH)-1:0] ram_raddr,
  input  logic [ENTRY_BITS-1:0]    ram_rdata
);

  import isq_pkg::*;

  localparam int AW = $clog2(DEPTH);
  localparam int LW = $clog2(DEPTH + 1);
  localparam int CW = ((LW > 5) ? LW : 5) + 1;

  localparam logic [3:0] S_INIT   = 4'd0;
  localparam logic [3:0] S_IDLE   = 4'd1;
  localparam logic [3:0] S_RD     = 4'd2;
  localparam logic [3:0] S_WR     = 4'd3;
  localparam logic [3:0] S_PUT    = 4'd4;
  localparam logic [3:0] S_ZERO   = 4'd5;
  localparam logic [3:0] S_FILL   = 4'd6;
  localparam logic [3:0] S_POPCAP = 4'd7;
  localparam logic [3:0] S_DONE   = 4'd8;

  logic [3:0]            state, state_next;
  logic [LW-1:0]         length, length_next;
  logic [CW-1:0]         wa, wa_next;
  logic [CW-1:0]         pos_r, pos_r_next;
  logic [CW-1:0]         amt_r, amt_r_next;
  logic [ENTRY_BITS-1:0] val_r, val_r_next;
  logic [ENTRY_BITS-1:0] popped, popped_next;
  status_t               status, status_next;
  logic                  shift_up, shift_up_next;

  logic [CW-1:0] len_x, depth_x, req_pos, req_amt, ins_pos, rd_ptr;

  assign len_x   = CW'(length);
  assign depth_x = CW'(DEPTH);
  assign req_pos = CW'(req.position);
  assign req_amt = CW'(req.amount);
  assign ins_pos = (req.req_type == OP_APPEND) ? len_x : req_pos;

  // insert reads the slot below the cursor, erase reads amount slots above
  assign rd_ptr    = shift_up ? (wa - CW'(1)) : (wa + amt_r);
  assign ram_raddr = (state == S_RD) ? rd_ptr[AW-1:0] : '0;

  assign in_ready = (state == S_IDLE);

  assign res.status       = status;
  assign res.popped_value = 16'(popped);
  assign res.length_after = 5'(length);

  always_comb begin
    state_next    = state;
    length_next   = length;
    wa_next       = wa;
    pos_r_next    = pos_r;
    amt_r_next    = amt_r;
    val_r_next    = val_r;
    popped_next   = popped;
    status_next   = status;
    shift_up_next = shift_up;
    ram_we        = 1'b0;
    ram_waddr     = wa[AW-1:0];
    ram_wdata     = '0;
    res_valid     = 1'b0;

    unique case (state)
      S_INIT: begin
        ram_we = 1'b1;
        if (wa == depth_x - CW'(1)) begin
          wa_next    = '0;
          state_next = S_IDLE;
        end else begin
          wa_next = wa + CW'(1);
        end
      end

      S_IDLE: begin
        if (in_fire) begin
          status_next = ST_OK;
          popped_next = '0;
          val_r_next  = ENTRY_BITS'(req.entry_value);
          pos_r_next  = req_pos;
          amt_r_next  = req_amt;
          state_next  = S_DONE;
          unique case (req.req_type) inside
            OP_APPEND, OP_INSERT: begin
              pos_r_next = ins_pos;
              if (len_x >= depth_x) begin
                status_next = ST_FULL;
              end else if (ins_pos > len_x) begin
                status_next = ST_RANGE;
              end else begin
                shift_up_next = 1'b1;
                wa_next       = len_x;
                state_next    = (ins_pos == len_x) ? S_PUT : S_RD;
              end
            end
            OP_ERASE: begin
              if (req_pos + req_amt > len_x) begin
                status_next = ST_RANGE;
              end else if (req_amt != '0) begin
                shift_up_next = 1'b0;
                if (req_pos + req_amt < len_x) begin
                  wa_next    = req_pos;
                  state_next = S_RD;
                end else begin
                  wa_next    = len_x - req_amt;
                  state_next = S_ZERO;
                end
              end
            end
            OP_POP: begin
              // slot 0 is on the read port this cycle
              if (length == '0) begin
                status_next = ST_EMPTY;
              end else begin
                shift_up_next = 1'b0;
                pos_r_next    = '0;
                amt_r_next    = CW'(1);
                state_next    = S_POPCAP;
              end
            end
            OP_CLEAR: begin
              length_next = '0;
            end
            OP_RESIZE: begin
              if (req_amt < len_x) begin
                length_next = LW'(req_amt);
              end else if (req_amt > len_x && req_amt >= depth_x) begin
                length_next = LW'(DEPTH);
                status_next = ST_CLAMPED;
              end else if (req_amt > len_x) begin
                length_next = LW'(req_amt);
              end else begin
                status_next = ST_SAME;
              end
            end
            OP_FILL: begin
              wa_next    = '0;
              state_next = S_FILL;
            end
            default: begin
              status_next = ST_RANGE;
            end
          endcase
        end
      end

      S_POPCAP: begin
        popped_next = ram_rdata;
        if (CW'(1) < len_x) begin
          wa_next    = '0;
          state_next = S_RD;
        end else begin
          wa_next    = len_x - CW'(1);
          state_next = S_ZERO;
        end
      end

      S_RD: begin
        state_next = S_WR;
      end

      S_WR: begin
        ram_we    = 1'b1;
        ram_wdata = ram_rdata;
        if (shift_up) begin
          wa_next    = wa - CW'(1);
          state_next = (wa - CW'(1) == pos_r) ? S_PUT : S_RD;
        end else if (wa + amt_r + CW'(1) < len_x) begin
          wa_next    = wa + CW'(1);
          state_next = S_RD;
        end else begin
          wa_next    = len_x - amt_r;
          state_next = S_ZERO;
        end
      end

      S_PUT: begin
        ram_we      = 1'b1;
        ram_waddr   = pos_r[AW-1:0];
        ram_wdata   = val_r;
        length_next = length + LW'(1);
        state_next  = S_DONE;
      end

      S_ZERO: begin
        // clear the vacated tail of an erase or pop
        ram_we = 1'b1;
        if (wa == len_x - CW'(1)) begin
          length_next = length - LW'(amt_r);
          state_next  = S_DONE;
        end else begin
          wa_next = wa + CW'(1);
        end
      end

      S_FILL: begin
        ram_we    = 1'b1;
        ram_wdata = val_r;
        if (wa == depth_x - CW'(1)) begin
          state_next = S_DONE;
        end else begin
          wa_next = wa + CW'(1);
        end
      end

      S_DONE: begin
        res_valid = res_free;
        if (res_free) begin
          state_next = S_IDLE;
        end
      end

      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= S_INIT;
      length <= '0;
      wa     <= '0;
    end else begin
      state  <= state_next;
      length <= length_next;
      wa     <= wa_next;
    end
  end

  always_ff @(posedge clk) begin
    pos_r    <= pos_r_next;
    amt_r    <= amt_r_next;
    val_r    <= val_r_next;
    popped   <= popped_next;
    status   <= status_next;
    shift_up <= shift_up_next;
  end

  `ISQ_ASSERT(a_len_bound, clk, rst, length <= LW'(DEPTH), "length exceeds depth")
  `ISQ_ASSERT(a_busy_after_accept, clk, rst, in_fire |=> !in_ready, "ready right after transfer")
  `ISQ_ASSERT(a_zero_in_list, clk, rst, (state == S_ZERO) |-> (wa < len_x), "tail clear past end")
  `ISQ_ASSERT(a_idle_no_write, clk, rst, (state == S_IDLE) |-> !ram_we, "slot write while idle")
  `ISQ_ASSERT_NR(a_reset_init, clk, $past(rst) |-> (state == S_INIT && length == '0), "reset state")

endmodule

[bench/isq_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// isq_checker
// Watches the request and response channels of indexed_shift_queue. Keeps a
// shadow copy of the slot list, works out the outcome of every request that
// transfers, and compares each response transfer field by field, in order.
// ----------------------------------------------------------------------------

module isq_checker #(
  parameter int DEPTH = 16
) (
  input  logic       clk,
  input  logic       rst,
  isq_req_if         req_mon,
  isq_rsp_if         rsp_mon,
  output int         mismatch_count,
  output int         pending_count,
  output int         checked_count,
  output logic [4:0] list_length
);
  import isq_pkg::*;

  logic [15:0] shadow_slots [DEPTH];
  int unsigned shadow_len;
  res_t        outcome_q [$];

  // remove cnt entries starting at first; vacated tail slots are zeroed
  function automatic void drop_run(int unsigned first, int unsigned cnt);
    for (int unsigned i = first; i + cnt < shadow_len; i++) shadow_slots[i] = shadow_slots[i + cnt];
    for (int unsigned i = shadow_len - cnt; i < shadow_len; i++) shadow_slots[i] = '0;
    shadow_len -= cnt;
  endfunction

  function automatic res_t apply_request(op_t op, int unsigned pos, int unsigned amt,
                                         logic [15:0] val);
    res_t r;
    r.status       = ST_OK;
    r.popped_value = '0;
    case (op)
      OP_APPEND: begin
        if (shadow_len >= DEPTH) begin
          r.status = ST_FULL;
        end else begin
          shadow_slots[shadow_len] = val;
          shadow_len++;
        end
      end
      OP_INSERT: begin
        if (shadow_len >= DEPTH) begin
          r.status = ST_FULL;
        end else if (pos > shadow_len) begin
          r.status = ST_RANGE;
        end else begin
          for (int unsigned i = shadow_len; i > pos; i--) shadow_slots[i] = shadow_slots[i - 1];
          shadow_slots[pos] = val;
          shadow_len++;
        end
      end
      OP_ERASE: begin
        if (pos + amt > shadow_len) r.status = ST_RANGE;
        else drop_run(pos, amt);
      end
      OP_POP: begin
        if (shadow_len == 0) begin
          r.status = ST_EMPTY;
        end else begin
          r.popped_value = shadow_slots[0];
          drop_run(0, 1);
        end
      end
      OP_CLEAR: begin
        // slot contents survive; only the length goes
        shadow_len = 0;
      end
      OP_RESIZE: begin
        if (amt < shadow_len) begin
          shadow_len = amt;
        end else if (amt > shadow_len && amt >= DEPTH) begin
          shadow_len = DEPTH;
          r.status   = ST_CLAMPED;
        end else if (amt > shadow_len) begin
          shadow_len = amt;
        end else begin
          r.status = ST_SAME;
        end
      end
      OP_FILL: begin
        for (int i = 0; i < DEPTH; i++) shadow_slots[i] = val;
      end
      default: begin
        r.status = ST_RANGE;
      end
    endcase
    r.length_after = 5'(shadow_len);
    return r;
  endfunction

  function automatic bit field_ok(string field, logic [15:0] want, logic [15:0] got);
    if (got === want) return 1'b1;
    $error("%s: expected 0x%0h, got 0x%0h", field, want, got);
    return 1'b0;
  endfunction

  always @(posedge clk) begin
    res_t want;
    if (rst) begin
      for (int i = 0; i < DEPTH; i++) shadow_slots[i] = '0;
      shadow_len = 0;
      outcome_q.delete();
      mismatch_count = 0;
      checked_count  = 0;
    end else begin
      // response first: a result can never belong to a request taken at the same edge
      if (rsp_mon.valid && rsp_mon.ready) begin
        if (outcome_q.size() == 0) begin
          $error("response transfer with no request outstanding: status %0d length %0d",
                 rsp_mon.status, rsp_mon.length_after);
          mismatch_count++;
        end else begin
          want = outcome_q.pop_front();
          if (!field_ok("status", want.status, rsp_mon.status)) mismatch_count++;
          if (!field_ok("popped_value", want.popped_value, rsp_mon.popped_value))
            mismatch_count++;
          if (!field_ok("length_after", want.length_after, rsp_mon.length_after))
            mismatch_count++;
          checked_count++;
        end
      end
      if (req_mon.valid && req_mon.ready)
        outcome_q.push_back(apply_request(op_t'(req_mon.req_type), req_mon.position,
                                          req_mon.amount, req_mon.entry_value));
    end
    pending_count <= outcome_q.size();
    list_length   <= 5'(shadow_len);
  end

endmodule

[bench/indexed_shift_queue_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// indexed_shift_queue_tb
// Drives list requests into indexed_shift_queue: a directed pass over the
// corner cases (empty, full, out-of-range, clamp, unchanged size, clear then
// regrow, fill), then grow/shrink phases of mostly well-formed random
// requests, with random gaps on the request side and stalls on the response.
// ----------------------------------------------------------------------------

module indexed_shift_queue_tb;
  import isq_pkg::*;

  localparam int  DEPTH         = 16;
  localparam op_t OP_UNKNOWN    = 3'd7;
  localparam int  RANDOM_ITEMS  = 850;
  localparam int  PHASE_ITEMS   = 50;
  localparam int  SETTLE_CYCLES = 64;
  localparam int  CYCLE_LIMIT   = 500000;

  logic       clk;
  logic       rst;
  bit         steady_flow;
  int         mismatch_count;
  int         pending_results;
  int         checked_results;
  logic [4:0] list_length;
  int         sent_per_op [8];
  int         cycle_count;

  isq_req_if req_bus ();
  isq_rsp_if rsp_bus ();

  indexed_shift_queue #(
    .DEPTH     (DEPTH),
    .ENTRY_BITS(16)
  ) DUT (
    .clk(clk),
    .rst(rst),
    .req(req_bus),
    .rsp(rsp_bus)
  );

  isq_checker #(
    .DEPTH(DEPTH)
  ) u_checker (
    .clk           (clk),
    .rst           (rst),
    .req_mon       (req_bus),
    .rsp_mon       (rsp_bus),
    .mismatch_count(mismatch_count),
    .pending_count (pending_results),
    .checked_count (checked_results),
    .list_length   (list_length)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // mostly short gaps, a few long ones, none while steady_flow is set
  function automatic int unsigned pick_gap();
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (steady_flow || roll < 50) return 0;
    if (roll < 93) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // response back-pressure
  initial begin
    int unsigned stall;
    rsp_bus.ready = 1'b0;
    @(posedge clk);
    forever begin
      stall = pick_gap();
      if (stall != 0) begin
        rsp_bus.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      rsp_bus.ready <= 1'b1;
      repeat ($urandom_range(1, 16)) @(posedge clk);
    end
  end

  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("Timed out after %0d cycles", cycle_count);
    $display("Verification failed");
    $finish;
  end

  // one transfer, then a random gap with valid low
  task automatic push_request(op_t op, logic [4:0] pos, logic [4:0] amt, logic [15:0] val);
    int unsigned gap;
    req_bus.valid       <= 1'b1;
    req_bus.req_type    <= op;
    req_bus.position    <= pos;
    req_bus.amount      <= amt;
    req_bus.entry_value <= val;
    @(posedge clk);
    while (!req_bus.ready) @(posedge clk);
    sent_per_op[op]++;
    gap = pick_gap();
    if (gap != 0) begin
      req_bus.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic drain_results();
    req_bus.valid <= 1'b0;
    do @(posedge clk); while (pending_results != 0);
  endtask

  // length is one transfer stale at worst; good enough to steer the mix
  task automatic send_random_item(bit grow);
    int unsigned pick;
    int unsigned len;
    int unsigned pos;
    int unsigned amt;
    int unsigned vroll;
    op_t         op;
    logic [15:0] val;
    len  = list_length;
    pick = $urandom_range(0, 99);
    if (pick < (grow ? 30 : 15)) op = OP_APPEND;
    else if (pick < (grow ? 55 : 30)) op = OP_INSERT;
    else if (pick < (grow ? 65 : 55)) op = OP_ERASE;
    else if (pick < 75) op = OP_POP;
    else if (pick < 86) op = OP_RESIZE;
    else if (pick < 91) op = OP_FILL;
    else if (pick < 96) op = OP_CLEAR;
    else if (pick < 98) op = OP_UNKNOWN;
    else op = OP_APPEND;
    val   = 16'($urandom());
    vroll = $urandom_range(0, 9);
    if (vroll == 0) val = '0;
    if (vroll == 1) val = '1;
    pos = $urandom_range(0, 31);
    amt = $urandom_range(0, 31);
    if ($urandom_range(0, 9) != 0) begin
      case (op)
        OP_INSERT: begin
          pos = $urandom_range(0, len);
        end
        OP_ERASE: begin
          pos = $urandom_range(0, len);
          amt = $urandom_range(0, len - pos);
        end
        OP_RESIZE: begin
          amt = $urandom_range(0, DEPTH);
        end
        default: ;
      endcase
    end
    push_request(op, 5'(pos), 5'(amt), val);
  endtask

  initial begin
    bit grow;
    rst                 = 1'b1;
    steady_flow         = 1'b0;
    req_bus.valid       = 1'b0;
    req_bus.req_type    = OP_APPEND;
    req_bus.position    = '0;
    req_bus.amount      = '0;
    req_bus.entry_value = '0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // corner cases, in an order that walks the list through empty and full
    push_request(OP_POP,     5'd0,  5'd0,  16'h1234);
    push_request(OP_ERASE,   5'd0,  5'd0,  16'h0000);
    push_request(OP_INSERT,  5'd1,  5'd0,  16'h1111);
    push_request(OP_RESIZE,  5'd0,  5'd0,  16'h0000);
    push_request(OP_APPEND,  5'd31, 5'd31, 16'h0000);
    push_request(OP_APPEND,  5'd0,  5'd0,  16'hFFFF);
    push_request(OP_INSERT,  5'd0,  5'd0,  16'hA5A5);
    push_request(OP_INSERT,  5'd3,  5'd0,  16'h5A5A);
    push_request(OP_ERASE,   5'd1,  5'd2,  16'h0000);
    push_request(OP_ERASE,   5'd31, 5'd31, 16'h0000);
    push_request(OP_RESIZE,  5'd0,  5'd5,  16'h0000);
    push_request(OP_RESIZE,  5'd0,  5'd1,  16'h0000);
    push_request(OP_CLEAR,   5'd0,  5'd0,  16'h0000);
    push_request(OP_RESIZE,  5'd0,  5'd16, 16'h0000);
    push_request(OP_APPEND,  5'd0,  5'd0,  16'hBEEF);
    push_request(OP_INSERT,  5'd0,  5'd0,  16'hCAFE);
    push_request(OP_FILL,    5'd0,  5'd0,  16'hFFFF);
    push_request(OP_POP,     5'd0,  5'd0,  16'h0000);
    push_request(OP_ERASE,   5'd0,  5'd15, 16'h0000);
    push_request(OP_RESIZE,  5'd0,  5'd31, 16'h0000);
    push_request(OP_UNKNOWN, 5'd31, 5'd31, 16'hFFFF);
    push_request(OP_FILL,    5'd0,  5'd0,  16'h0000);
    drain_results();

    for (int phase = 0; phase < RANDOM_ITEMS / PHASE_ITEMS; phase++) begin
      grow        = $urandom_range(0, 1);
      steady_flow = ($urandom_range(0, 3) == 0);
      repeat (PHASE_ITEMS) send_random_item(grow);
      if (phase % 4 == 3) drain_results();
    end

    drain_results();
    repeat (SETTLE_CYCLES) @(posedge clk);

    $display("Sent %0d requests: append %0d, insert %0d, erase %0d, pop %0d, clear %0d,",
             sent_per_op.sum(), sent_per_op[OP_APPEND], sent_per_op[OP_INSERT],
             sent_per_op[OP_ERASE], sent_per_op[OP_POP], sent_per_op[OP_CLEAR]);
    $display("resize %0d, fill %0d, unknown %0d; %0d responses checked under gaps and stalls",
             sent_per_op[OP_RESIZE], sent_per_op[OP_FILL], sent_per_op[OP_UNKNOWN],
             checked_results);
    if (mismatch_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
